/* design/hmd_pkg.sv */
package hmd_pkg;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} hmd_in_t;

	typedef struct packed {
		logic       fwd_valid;
		logic [7:0] fwd_byte;
		logic [9:0] pwm_level;
		logic [2:0] drive_mode;
		logic       sine_mode;
		logic [6:0] period_count;
		logic       led_update;
		logic [4:0] led_index;
	} hmd_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCALE,
		ST_OUT
	} hmd_state_t;

	typedef struct packed {
		logic exec;
		logic scale;
	} hmd_cmd_t;

	localparam logic [1:0] POL_NONE = 2'd0;
	localparam logic [1:0] POL_POS  = 2'd1;
	localparam logic [1:0] POL_NEG  = 2'd2;

	localparam logic [2:0] MODE_COAST  = 3'd0;
	localparam logic [2:0] MODE_SIN_P  = 3'd1;
	localparam logic [2:0] MODE_SIN_N  = 3'd2;
	localparam logic [2:0] MODE_SQ_P   = 3'd3;
	localparam logic [2:0] MODE_SQ_N   = 3'd4;
	localparam logic [2:0] MODE_SQ_NUL = 3'd5;

	localparam logic [1:0] PH_ADDR = 2'd0;
	localparam logic [1:0] PH_DUTY = 2'd1;
	localparam logic [1:0] PH_WAVE = 2'd2;

	localparam logic [9:0] SINE_TOP = 10'd799;
	localparam logic [7:0] WIN_LAST = 8'd199;
	localparam logic [7:0] WIN_HALF = 8'd100;

	function automatic logic [6:0] sine_mag(input logic [4:0] q);
		logic [6:0] t [0:16];
		t = '{7'd0, 7'd12, 7'd25, 7'd37, 7'd49, 7'd60, 7'd71, 7'd81, 7'd90,
			7'd99, 7'd106, 7'd113, 7'd118, 7'd122, 7'd125, 7'd127, 7'd127};
		return (q <= 5'd16) ? t[q] : t[5'd0];
	endfunction

	// magnitude of the signed table entry, from quarter-wave symmetry
	function automatic logic [6:0] sine_abs(input logic [5:0] i);
		logic [4:0] k;
		k = i[4:0];
		return (k <= 5'd16) ? sine_mag(k) : sine_mag(5'd0 + 5'(6'd32 - {1'b0, k}));
	endfunction

	function automatic logic [6:0] sine_us(input logic [2:0] f);
		logic [6:0] r;
		case (f)
			3'd0: r = 7'd127;
			3'd1: r = 7'd108;
			3'd2: r = 7'd92;
			3'd3: r = 7'd78;
			3'd4: r = 7'd66;
			3'd5: r = 7'd57;
			3'd6: r = 7'd49;
			default: r = 7'd41;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] sq_period(input logic [2:0] f);
		logic [6:0] r;
		case (f)
			3'd0: r = 7'd85;
			3'd1: r = 7'd72;
			3'd2: r = 7'd60;
			3'd3: r = 7'd52;
			3'd4: r = 7'd44;
			3'd5: r = 7'd37;
			3'd6: r = 7'd32;
			default: r = 7'd27;
		endcase
		return r;
	endfunction

endpackage

/* design/haptic_motor_drive_controller.sv */
// haptic motor drive controller
// in channel: in_valid/in_ready carry one word (opcode, rx_byte); opcode 0 is a
// received serial byte for the daisy-chain protocol, opcode 1 a waveform tick
// out channel: out_valid/out_ready carry exactly one result word per input word
// (forwarded byte, pwm compare level, bridge mode, period, led index)
// after acceptance the word passes the exec state (decode and update), then
// the scale state (sine scale/clamp or amplitude reciprocal), then the out
// state, where out_valid is high and the result can be taken
// the controller sequences one word at a time through the datapath
// a new word is accepted in the same cycle that the pending result is taken
// if the receiver stalls, the result holds and no new word is taken
// reset: protocol awaits an address, drive stopped (coast, level 0), sine
// waveform with frequency select 3, led index 0; ticks are ignored until a
// full command has been received
module haptic_motor_drive_controller import hmd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hmd_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output hmd_out_t out_data
);

	hmd_cmd_t cmd;

	// controller: sequence of exec, scale, present
	hmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath: protocol and drive state
	hmd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (in_valid & in_ready),
		.din    (in_data),
		.cmd    (cmd),
		.dout   (out_data)
	);

endmodule

/* design/hmd_ctrl.sv */
module hmd_ctrl import hmd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output hmd_cmd_t cmd
);

	hmd_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = ST_SCALE;
			ST_SCALE: state_nxt = ST_OUT;
			ST_OUT:   if (out_ready) state_nxt = in_valid ? ST_EXEC : ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_EXEC:  cmd.exec = 1'b1;
			ST_SCALE: cmd.scale = 1'b1;
			ST_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_exec_after: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> cmd.scale) else $error("scale did not follow exec");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale |=> out_valid) else $error("result not presented");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.exec) else $error("accepted word not run");
`endif

endmodule

/* design/hmd_dp.sv */
module hmd_dp import hmd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  hmd_in_t  din,
	input  hmd_cmd_t cmd,
	output hmd_out_t dout
);

	hmd_in_t    in_q;
	logic [1:0] phase_q;
	logic [4:0] duty_q;
	logic       sine_q;
	logic [2:0] freq_q;
	logic [6:0] pct_q;
	logic [9:0] amp_q;
	logic [5:0] sph_q;
	logic [1:0] pol_q;
	logic [7:0] win_q;
	logic       br_q, full_q, run_q;
	logic [9:0] pwm_q;
	logic [2:0] mode_q;
	logic [4:0] led_q;
	logic       fv_q, ledup_q;
	logic [7:0] fb_q;
	// pending sine product (multiply in exec, clamp in scale)
	logic       sscale_q;
	logic [16:0] prod_q;
	// pending amp scale for a sine command
	logic       ascale_q;
	logic [16:0] ampm_q;

	logic [5:0] addr;
	logic [6:0] pct_new;
	logic [11:0] d85;
	logic [5:0] si;
	logic [6:0] smag;
	logic       szero, sneg;
	logic [1:0] sgn;
	logic [7:0] widx;
	logic       on;
	logic [1:0] want;
	logic [9:0] sqtop;
	logic [9:0] fwd;
	logic [16:0] ampr;

	assign addr  = in_q.rx_byte[6:1];
	assign d85   = 12'(duty_q) * 12'd85;
	assign pct_new = (duty_q == 5'd0) ? 7'd0 :
		((7'd15 + 7'(d85 >> 5)) > 7'd100 ? 7'd100 : 7'd15 + 7'(d85 >> 5));
	assign si    = sph_q + 6'd1;
	assign smag  = sine_abs(si);
	assign szero = (smag == 7'd0);
	assign sneg  = si[5];
	assign sgn   = szero ? pol_q : (sneg ? POL_NEG : POL_POS);
	assign widx  = (win_q >= WIN_LAST) ? 8'd0 : win_q + 8'd1;
	assign on    = (widx < {1'b0, pct_q}) ||
		(widx >= WIN_HALF && 9'(widx) < 9'd100 + 9'(pct_q));
	assign want  = (widx >= WIN_HALF) ? POL_NEG : POL_POS;
	assign sqtop = 10'(({3'd0, sq_period(freq_q)} + 10'd1) << 2) - 10'd1;
	assign fwd   = (prod_q[16:7] >= SINE_TOP) ? SINE_TOP : prod_q[16:7];
	// (799*pct+50)/100 via reciprocal: x*5243 >> 19 is exact for x < 43690 and
	// for every percentage the duty decode can give (none leaves x mod 100 at 99)
	assign ampr  = 17'((34'(ampm_q) * 34'd5243) >> 19);

	always_ff @(posedge clk) begin
		if (load) in_q <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR; duty_q <= '0; sine_q <= 1'b1; freq_q <= 3'd3;
			pct_q <= '0; amp_q <= '0; sph_q <= '0; pol_q <= POL_NONE;
			win_q <= '0; br_q <= 1'b0; full_q <= 1'b0; run_q <= 1'b0;
			pwm_q <= '0; mode_q <= MODE_COAST; led_q <= '0;
			fv_q <= 1'b0; fb_q <= '0; ledup_q <= 1'b0;
			sscale_q <= 1'b0; ascale_q <= 1'b0; prod_q <= '0; ampm_q <= '0;
		end else if (cmd.exec) begin
			fv_q <= 1'b0; fb_q <= '0; ledup_q <= 1'b0;
			sscale_q <= 1'b0; ascale_q <= 1'b0;
			if (!in_q.opcode) begin
				if (!in_q.rx_byte[7]) begin
					phase_q <= PH_ADDR;
					if (addr != 6'd0) begin
						fv_q <= 1'b1;
						fb_q <= {1'b0, addr - 6'd1, in_q.rx_byte[0]};
					end else if (!in_q.rx_byte[0]) begin
						mode_q <= MODE_COAST; pwm_q <= '0; pct_q <= '0;
						br_q <= 1'b0; full_q <= 1'b0; run_q <= 1'b0;
					end else begin
						phase_q <= PH_DUTY;
					end
				end else if (phase_q == PH_ADDR) begin
					fv_q <= 1'b1; fb_q <= in_q.rx_byte;
				end else if (phase_q == PH_DUTY) begin
					duty_q <= in_q.rx_byte[4:0];
					phase_q <= PH_WAVE;
				end else begin
					sine_q <= in_q.rx_byte[3];
					freq_q <= in_q.rx_byte[2:0];
					pct_q <= pct_new;
					if (led_q != duty_q) begin
						led_q <= duty_q; ledup_q <= 1'b1;
					end
					if (in_q.rx_byte[3]) begin
						mode_q <= MODE_COAST; pwm_q <= '0; sph_q <= '0;
						pol_q <= POL_NONE;
						ascale_q <= 1'b1;
						ampm_q <= 17'(pct_new) * 17'd799 + 17'd50;
					end else begin
						mode_q <= MODE_SQ_NUL; win_q <= '0; br_q <= 1'b0;
						full_q <= 1'b0; pol_q <= POL_NONE;
					end
					run_q <= 1'b1;
					phase_q <= PH_ADDR;
				end
			end else if (run_q) begin
				if (sine_q) begin
					sph_q <= si;
					pol_q <= sgn;
					if (amp_q == 10'd0) begin
						mode_q <= MODE_COAST; pwm_q <= '0;
					end else begin
						if (sgn != pol_q) mode_q <= (sgn == POL_POS) ? MODE_SIN_P : MODE_SIN_N;
						prod_q <= 17'(amp_q) * 17'(smag) + 17'd64;
						sscale_q <= 1'b1;
					end
				end else begin
					win_q <= widx;
					if (on) begin
						if (!br_q || pol_q != want) begin
							mode_q <= (want == POL_POS) ? MODE_SQ_P : MODE_SQ_N;
							pol_q <= want; br_q <= 1'b1;
						end
						if (!full_q) begin
							pwm_q <= sqtop; full_q <= 1'b1;
						end
					end else begin
						if (br_q) begin
							mode_q <= MODE_SQ_NUL; br_q <= 1'b0;
						end
						if (full_q) begin
							pwm_q <= '0; full_q <= 1'b0;
						end
					end
				end
			end
		end else if (cmd.scale) begin
			if (sscale_q) pwm_q <= SINE_TOP - fwd;
			if (ascale_q) amp_q <= ampr[9:0];
		end
	end

	always_comb begin
		dout.fwd_valid    = fv_q;
		dout.fwd_byte     = fb_q;
		dout.pwm_level    = pwm_q;
		dout.drive_mode   = mode_q;
		dout.sine_mode    = sine_q;
		dout.period_count = sine_q ? sine_us(freq_q) : sq_period(freq_q);
		dout.led_update   = ledup_q;
		dout.led_index    = led_q;
	end

`ifndef ASSERT_OFF
	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_q <= SINE_TOP) else $error("pwm level out of range");
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> (pwm_q == 10'd0 && mode_q == MODE_COAST))
		else $error("stop left bridge driven");
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		!fv_q |-> fb_q == 8'd0) else $error("forward byte without valid");
`endif

endmodule
